@@ rtl/sitd_pkg.sv @@
// Package for the signed integer to padded decimal text converter.
// Holds the shared constants, the character codes and the queue entry type.
// No dependencies.
`default_nettype none

package sitd_pkg;

   localparam int VALUE_W          = 32;
   localparam int MIN_WIDTH_W      = 6;
   localparam int CHAR_W           = 8;
   localparam int DIGIT_DEPTH      = 10;
   localparam int DIGIT_W          = 4;
   localparam int COUNT_W          = 4;
   localparam int MAX_CHARS_DEFAULT = 32;
   localparam int QUEUE_DEPTH      = 2;

   localparam logic [MIN_WIDTH_W-1:0] MIN_WIDTH_RESET = 6'd3;
   localparam logic [VALUE_W-1:0]     RECIP_TEN       = 32'hCCCC_CCCD;
   localparam int                     RECIP_SHIFT     = 35;

   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

   typedef struct packed {
      logic                                   neg;
      logic [COUNT_W-1:0]                     count;
      logic [DIGIT_DEPTH-1:0][DIGIT_W-1:0]    digits;
   } sitd_entry_type;

endpackage

`default_nettype wire

@@ rtl/sitd_front.sv @@
// Front part: accepts an integer, forms its magnitude and splits it into
// decimal digits, one digit per cycle, then hands the digits to the queue.
// Depends on sitd_pkg.
`default_nettype none

module sitd_front (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            push,
   input  wire logic [sitd_pkg::VALUE_W-1:0]    value,
   output logic                                 full,
   input  wire logic                            q_full,
   output logic                                 q_push,
   output sitd_pkg::sitd_entry_type             q_entry
);

   typedef enum logic [2:0] {
      F_IDLE = 3'b001,
      F_CONV = 3'b010,
      F_DONE = 3'b100
   } front_state_type;

   front_state_type state_ff, state_in;

   logic [sitd_pkg::VALUE_W-1:0]   mag_ff, mag_in;
   logic                           neg_ff, neg_in;
   logic [sitd_pkg::COUNT_W-1:0]   cnt_ff, cnt_in;
   logic [sitd_pkg::DIGIT_W-1:0]   digit_store_ff [sitd_pkg::DIGIT_DEPTH];

   logic                           accept;
   logic [2*sitd_pkg::VALUE_W-1:0] prod;
   logic [sitd_pkg::VALUE_W-1:0]   quot;
   logic [sitd_pkg::VALUE_W-1:0]   quot_ten;
   logic [sitd_pkg::VALUE_W-1:0]   rem;
   logic                           conv_end;

   always_comb begin
      prod     = (2*sitd_pkg::VALUE_W)'(mag_ff) * (2*sitd_pkg::VALUE_W)'(sitd_pkg::RECIP_TEN);
      quot     = sitd_pkg::VALUE_W'(prod[2*sitd_pkg::VALUE_W-1:sitd_pkg::RECIP_SHIFT]);
      quot_ten = (quot << 3) + (quot << 1);
      rem      = mag_ff - quot_ten;
      conv_end = (quot == '0) ||
                 (cnt_ff == sitd_pkg::COUNT_W'(sitd_pkg::DIGIT_DEPTH - 1));
   end

   assign full   = !((state_ff == F_IDLE) || ((state_ff == F_DONE) && !q_full));
   assign accept = push && !full;
   assign q_push = (state_ff == F_DONE) && !q_full;

   always_comb begin
      q_entry.neg   = neg_ff;
      q_entry.count = cnt_ff;
      for (int i = 0; i < sitd_pkg::DIGIT_DEPTH; i++) begin
         q_entry.digits[i] = digit_store_ff[i];
      end
   end

   always_comb begin
      state_in = state_ff;
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (accept) begin
               state_in = F_CONV;
            end
         end
         F_CONV: begin
            mag_in = quot;
            cnt_in = cnt_ff + 1'b1;
            if (conv_end) begin
               state_in = F_DONE;
            end
         end
         F_DONE: begin
            if (accept) begin
               state_in = F_CONV;
            end else if (q_push) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
      if (accept) begin
         neg_in = value[sitd_pkg::VALUE_W-1];
         mag_in = value[sitd_pkg::VALUE_W-1] ? (~value + 1'b1) : value;
         cnt_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         cnt_ff   <= '0;
         neg_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         neg_ff   <= neg_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      if (state_ff == F_CONV) begin
         digit_store_ff[cnt_ff] <= rem[sitd_pkg::DIGIT_W-1:0];
      end
   end

endmodule

`default_nettype wire

@@ rtl/sitd_queue.sv @@
// Short queue of digit entries between the front and the back part.
// Depends on sitd_pkg.
`default_nettype none

module sitd_queue (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       wr_en,
   input  sitd_pkg::sitd_entry_type        wr_data,
   output logic                            q_full,
   input  wire logic                       rd_en,
   output logic                            rd_valid,
   output sitd_pkg::sitd_entry_type        rd_data
);

   localparam int QPW = (sitd_pkg::QUEUE_DEPTH > 1) ? $clog2(sitd_pkg::QUEUE_DEPTH) : 1;
   localparam int FCW = $clog2(sitd_pkg::QUEUE_DEPTH + 1);
   localparam logic [QPW-1:0] LAST_SLOT = QPW'(sitd_pkg::QUEUE_DEPTH - 1);
   localparam logic [FCW-1:0] FULL_FILL = FCW'(sitd_pkg::QUEUE_DEPTH);

   sitd_pkg::sitd_entry_type slot_ff [sitd_pkg::QUEUE_DEPTH];

   logic [QPW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FCW-1:0] fill_ff, fill_in;
   logic           do_wr, do_rd;

   assign q_full   = (fill_ff == FULL_FILL);
   assign rd_valid = (fill_ff != '0);
   assign rd_data  = slot_ff[rd_ptr_ff];
   assign do_wr    = wr_en && !q_full;
   assign do_rd    = rd_en && rd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

@@ rtl/sitd_back.sv @@
// Back part: takes a digit entry, works out sign and padding against the
// minimum width and, while the output register is not stalled, emits one character per cycle into it.
// Depends on sitd_pkg.
`default_nettype none

module sitd_back #(
   parameter int MAX_CHARS = sitd_pkg::MAX_CHARS_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic [sitd_pkg::MIN_WIDTH_W-1:0]  min_width,
   input  wire logic                              q_valid,
   input  sitd_pkg::sitd_entry_type               q_data,
   output logic                                   q_pop,
   output logic                                   empty,
   input  wire logic                              pop,
   output logic [sitd_pkg::CHAR_W-1:0]            rsp_character,
   output logic                                   rsp_last
);

   localparam int PW = $clog2(MAX_CHARS + 1);
   localparam int CW = (PW > sitd_pkg::MIN_WIDTH_W) ? PW : sitd_pkg::MIN_WIDTH_W;

   sitd_pkg::sitd_entry_type cur_ff;
   logic [PW-1:0]            total_ff, total_in;
   logic [PW-1:0]            lead_ff, lead_in;
   logic [PW-1:0]            pos_ff, pos_in;
   logic                     busy_ff, busy_in;
   logic                     out_valid_ff, out_valid_in;
   logic [sitd_pkg::CHAR_W-1:0] char_ff;
   logic                     last_ff;

   logic [CW-1:0]            width_ext;
   logic [CW-1:0]            limit_cw;
   logic [PW-1:0]            limit;
   logic [PW-1:0]            text_len;
   logic                     advance;
   logic                     last_char;
   logic                     load;
   logic [PW-1:0]            idx;
   logic [sitd_pkg::DIGIT_W-1:0] idx4;
   logic [sitd_pkg::DIGIT_W-1:0] digit;
   logic [sitd_pkg::CHAR_W-1:0]  char_next;

   always_comb begin
      width_ext = CW'(min_width);
      limit_cw  = (width_ext > CW'(MAX_CHARS)) ? CW'(MAX_CHARS) : width_ext;
      limit     = limit_cw[PW-1:0];
      text_len  = PW'(q_data.count) + PW'(q_data.neg);
      total_in  = (limit > text_len) ? limit : text_len;
      lead_in   = total_in - PW'(q_data.count);
   end

   assign advance   = !out_valid_ff || pop;
   assign last_char = (pos_ff == total_ff - 1'b1);
   assign load      = q_valid && (!busy_ff || (advance && last_char));
   assign q_pop     = load;

   always_comb begin
      idx   = total_ff - 1'b1 - pos_ff;
      idx4  = idx[sitd_pkg::DIGIT_W-1:0];
      digit = (idx4 < sitd_pkg::DIGIT_W'(sitd_pkg::DIGIT_DEPTH)) ? cur_ff.digits[idx4] : '0;
      if (cur_ff.neg && (pos_ff == '0)) begin
         char_next = sitd_pkg::CHAR_MINUS;
      end else if (pos_ff < lead_ff) begin
         char_next = sitd_pkg::CHAR_ZERO;
      end else begin
         char_next = sitd_pkg::CHAR_ZERO + sitd_pkg::CHAR_W'(digit);
      end
   end

   always_comb begin
      busy_in = busy_ff;
      pos_in  = pos_ff;
      if (load) begin
         busy_in = 1'b1;
         pos_in  = '0;
      end else if (busy_ff && advance) begin
         pos_in = pos_ff + 1'b1;
         if (last_char) begin
            busy_in = 1'b0;
         end
      end
      out_valid_in = out_valid_ff;
      if (busy_ff && advance) begin
         out_valid_in = 1'b1;
      end else if (pop && out_valid_ff) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         pos_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         pos_ff       <= pos_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cur_ff   <= q_data;
         total_ff <= total_in;
         lead_ff  <= lead_in;
      end
      if (busy_ff && advance) begin
         char_ff <= char_next;
         last_ff <= last_char;
      end
   end

   assign empty         = !out_valid_ff;
   assign rsp_character = char_ff;
   assign rsp_last      = last_ff;

endmodule

`default_nettype wire

@@ rtl/signed_int_to_padded_decimal.sv @@
// Top level of the signed integer to zero-padded decimal text converter.
// Instantiates sitd_front, sitd_queue and sitd_back; depends on sitd_pkg.
//
//   Channel   Ports                                   Handshake
//   input     push, full, req_value[31:0]             push && !full
//   result    empty, pop, rsp_character[7:0], rsp_last  pop && !empty
//   config    csr_write_enable, csr_write_data[5:0]   csr_write_enable
//
// The front splits off one decimal digit of the magnitude per cycle and
// takes no new value while it converts, but accepts the next one while
// it hands an entry to the queue; the back emits one character per cycle
// while its output is not stalled. Reset is synchronous and restores the
// minimum width to three. Either side may stall freely; a two-entry queue
// and the output register keep the two halves apart.
`default_nettype none

module signed_int_to_padded_decimal #(
   parameter int MAX_CHARS = sitd_pkg::MAX_CHARS_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              push,
   output logic                                   full,
   input  wire logic signed [sitd_pkg::VALUE_W-1:0] req_value,
   output logic                                   empty,
   input  wire logic                              pop,
   output logic [sitd_pkg::CHAR_W-1:0]            rsp_character,
   output logic                                   rsp_last,
   input  wire logic                              csr_write_enable,
   input  wire logic [sitd_pkg::MIN_WIDTH_W-1:0]  csr_write_data
);

   logic [sitd_pkg::MIN_WIDTH_W-1:0] min_width_ff;

   logic                     q_full;
   logic                     q_push;
   sitd_pkg::sitd_entry_type q_wr_data;
   logic                     q_pop;
   logic                     q_valid;
   sitd_pkg::sitd_entry_type q_rd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_width_ff <= sitd_pkg::MIN_WIDTH_RESET;
      end else if (csr_write_enable) begin
         min_width_ff <= csr_write_data;
      end
   end

   sitd_front u_front (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .value   (req_value),
      .full    (full),
      .q_full  (q_full),
      .q_push  (q_push),
      .q_entry (q_wr_data)
   );

   sitd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (q_push),
      .wr_data  (q_wr_data),
      .q_full   (q_full),
      .rd_en    (q_pop),
      .rd_valid (q_valid),
      .rd_data  (q_rd_data)
   );

   sitd_back #(
      .MAX_CHARS (MAX_CHARS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .min_width     (min_width_ff),
      .q_valid       (q_valid),
      .q_data        (q_rd_data),
      .q_pop         (q_pop),
      .empty         (empty),
      .pop           (pop),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

endmodule

`default_nettype wire

@@ rtl/sitd_checker.sv @@
// Port-level checker for the padded decimal converter, bound to the top level.
// Depends on sitd_pkg and signed_int_to_padded_decimal.
`default_nettype none

module sitd_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             full,
   input wire logic                             empty,
   input wire logic                             pop,
   input wire logic [sitd_pkg::CHAR_W-1:0]      rsp_character,
   input wire logic                             rsp_last
);

   a_reset_empty : assert property (@(posedge clock) reset |=> empty)
      else $error("Result queue is not empty after reset.");

   a_reset_ready : assert property (@(posedge clock) reset |=> !full)
      else $error("Input is not ready after reset.");

   a_stall_hold : assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_character) && $stable(rsp_last)))
      else $error("Stalled item changed.");

   a_char_legal : assert property (@(posedge clock) disable iff (reset)
      !empty |-> ((rsp_character == sitd_pkg::CHAR_MINUS) ||
                  ((rsp_character >= sitd_pkg::CHAR_ZERO) &&
                   (rsp_character <= sitd_pkg::CHAR_NINE))))
      else $error("Item is not a sign or a digit.");

   a_sign_not_last : assert property (@(posedge clock) disable iff (reset)
      (!empty && (rsp_character == sitd_pkg::CHAR_MINUS)) |-> !rsp_last)
      else $error("Sign character closed a number.");

endmodule

bind signed_int_to_padded_decimal sitd_checker u_sitd_checker (
   .clock         (clock),
   .reset         (reset),
   .full          (full),
   .empty         (empty),
   .pop           (pop),
   .rsp_character (rsp_character),
   .rsp_last      (rsp_last)
);

`default_nettype wire
